// ===== hw/rtl/tovl_pkg.sv =====
package tovl_pkg;

	// Font and string geometry
	localparam int GLYPH_COUNT = 128;
	localparam int FONT_ROWS   = 12;
	localparam int FONT_COLS   = 8;
	localparam int TEXT_SLOTS  = 24;
	localparam int FONT_DEPTH  = GLYPH_COUNT * FONT_ROWS;

	localparam int GLYPH_W = $clog2(GLYPH_COUNT);
	localparam int SLOT_W  = $clog2(TEXT_SLOTS);
	localparam int ROW_W   = $clog2(FONT_ROWS);
	localparam int COL_W   = $clog2(FONT_COLS);
	localparam int FADDR_W = $clog2(FONT_DEPTH);
	localparam int TW_W    = $clog2(TEXT_SLOTS * FONT_COLS + 1);

	// Strip placement
	localparam int EDGE_GAP_X = 6;
	localparam int EDGE_GAP_Y = 4;
	localparam int PAD_H      = 3;
	localparam int PAD_V      = 2;
	localparam int STRIP_H    = FONT_ROWS + 2 * PAD_V;

	typedef logic [11:0] coord_t;
	typedef logic [7:0]  chan_t;
	typedef logic [1:0]  mode_t;
	typedef logic [10:0] taddr_t;
	typedef logic [7:0]  tdata_t;
	typedef logic [4:0]  len_t;
	typedef logic [2:0]  cfg_idx_t;
	typedef logic [11:0] cfg_word_t;

	// Item modes
	localparam mode_t MODE_PIXEL = 2'd0;
	localparam mode_t MODE_FONT  = 2'd1;
	localparam mode_t MODE_GLYPH = 2'd2;

	// Register indexes
	localparam cfg_idx_t REG_IMAGE_WIDTH  = 3'd0;
	localparam cfg_idx_t REG_IMAGE_HEIGHT = 3'd1;
	localparam cfg_idx_t REG_STAMP_ENABLE = 3'd2;
	localparam cfg_idx_t REG_LABEL_ENABLE = 3'd3;
	localparam cfg_idx_t REG_STAMP_LENGTH = 3'd4;
	localparam cfg_idx_t REG_LABEL_LENGTH = 3'd5;

	localparam coord_t WIDTH_RESET  = 12'd640;
	localparam coord_t HEIGHT_RESET = 12'd480;

	typedef struct packed {
		coord_t width;
		coord_t height;
		logic   stamp_en;
		logic   label_en;
		len_t   stamp_len;
		len_t   label_len;
	} cfg_t;

	typedef struct packed {
		chan_t red;
		chan_t green;
		chan_t blue;
	} rgb_t;

	localparam rgb_t RGB_WHITE = '{red: 8'hFF, green: 8'hFF, blue: 8'hFF};

	typedef struct packed {
		mode_t  mode;
		coord_t x;
		coord_t y;
		rgb_t   rgb;
		taddr_t addr;
		tdata_t data;
	} item_t;

	typedef struct packed {
		logic              rect;
		logic              text;
		logic [SLOT_W-1:0] slot;
		logic [COL_W-1:0]  col;
		logic [ROW_W-1:0]  row;
	} strip_hit_t;

	typedef struct packed {
		logic       pixel;
		logic       font_we;
		logic       glyph_we;
		rgb_t       rgb;
		taddr_t     addr;
		tdata_t     data;
		strip_hit_t stamp;
		strip_hit_t label;
	} loc_t;

	typedef struct packed {
		rgb_t             rgb;
		logic             stamp_rect;
		logic             stamp_text;
		logic [COL_W-1:0] stamp_col;
		logic             label_rect;
		logic             label_text;
		logic [COL_W-1:0] label_col;
	} fetch_t;

	// x/3 for 8-bit x: x*171 >> 9 is exact over 0..255
	function automatic chan_t div3(input chan_t x);
		logic [16:0] prod;
		prod = 17'(x) * 17'd171;
		return prod[16:9];
	endfunction

	function automatic rgb_t div3_rgb(input rgb_t c);
		rgb_t r;
		r.red   = div3(c.red);
		r.green = div3(c.green);
		r.blue  = div3(c.blue);
		return r;
	endfunction

endpackage

// ===== hw/rtl/tovl_if.sv =====
interface tovl_in_if;
	import tovl_pkg::*;

	logic   valid;
	logic   ready;
	mode_t  mode;
	coord_t pix_x;
	coord_t pix_y;
	chan_t  pix_red;
	chan_t  pix_green;
	chan_t  pix_blue;
	taddr_t table_address;
	tdata_t table_data;

	modport source (
		output valid, mode, pix_x, pix_y, pix_red, pix_green, pix_blue,
		       table_address, table_data,
		input  ready
	);
	modport sink (
		input  valid, mode, pix_x, pix_y, pix_red, pix_green, pix_blue,
		       table_address, table_data,
		output ready
	);
endinterface

interface tovl_out_if;
	import tovl_pkg::*;

	logic  valid;
	logic  ready;
	chan_t out_red;
	chan_t out_green;
	chan_t out_blue;

	modport source (output valid, out_red, out_green, out_blue, input ready);
	modport sink (input valid, out_red, out_green, out_blue, output ready);
endinterface

// ===== hw/rtl/text_overlay_pixel_compositor.sv =====
// A pixel item accepted into s1 moves through the registers s2 to s4 and shows its result on the overlay port from s5.
// Throughput: one item per clock, set by the five-stage valid/ready pipeline; while a finished
//   result waits at the output register, only empty stages ahead of it take new items.
// Load items (font rows, glyph indexes) and mode 3 items use a slot but give no result.
// Reset (arst_n low, asynchronous) empties the pipeline and restores the registers;
//   the font store and glyph strings keep no reset and hold garbage until written.
module text_overlay_pixel_compositor (
	input  logic                 clk,
	input  logic                 arst_n,
	tovl_in_if.sink              feed,
	tovl_out_if.source           overlay,
	input  logic                 cfg_we,
	input  tovl_pkg::cfg_idx_t   cfg_index,
	input  tovl_pkg::cfg_word_t  cfg_data
);
	import tovl_pkg::*;

	// Pipeline map
	//   s1  input register
	//   s2  strip geometry: rectangle/text tests, glyph slot, column, font row
	//   s3  glyph string lookup and write, font address, font RAM read or write
	//   s4  stamp strip darken and paint
	//   s5  label strip darken and paint, output register
	// Every stage moves when it is empty or the stage after it moves, so a
	// stall at the output fills bubbles before it pushes back on the feed.
	// Glyph writes and font writes happen in the same stage as their reads,
	// so a load item always takes effect for the pixels behind it.

	cfg_t   cfg_q;
	item_t  in_item;

	logic   loc_valid, loc_ready;
	loc_t   loc;
	logic   fetch_valid, fetch_ready;
	fetch_t fetch;
	tdata_t stamp_bits, label_bits;
	rgb_t   out_rgb;

	// Configuration registers; the user must write them only while the pipeline is empty, the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width     <= WIDTH_RESET;
			cfg_q.height    <= HEIGHT_RESET;
			cfg_q.stamp_en  <= 1'b0;
			cfg_q.label_en  <= 1'b0;
			cfg_q.stamp_len <= '0;
			cfg_q.label_len <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:  cfg_q.width     <= cfg_data[11:0];
				REG_IMAGE_HEIGHT: cfg_q.height    <= cfg_data[11:0];
				REG_STAMP_ENABLE: cfg_q.stamp_en  <= cfg_data[0];
				REG_LABEL_ENABLE: cfg_q.label_en  <= cfg_data[0];
				REG_STAMP_LENGTH: cfg_q.stamp_len <= cfg_data[4:0];
				REG_LABEL_LENGTH: cfg_q.label_len <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	assign in_item.mode      = feed.mode;
	assign in_item.x         = feed.pix_x;
	assign in_item.y         = feed.pix_y;
	assign in_item.rgb.red   = feed.pix_red;
	assign in_item.rgb.green = feed.pix_green;
	assign in_item.rgb.blue  = feed.pix_blue;
	assign in_item.addr      = feed.table_address;
	assign in_item.data      = feed.table_data;

	tovl_locate u_locate (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (feed.valid),
		.in_ready  (feed.ready),
		.in_item   (in_item),
		.out_valid (loc_valid),
		.out_ready (loc_ready),
		.out_loc   (loc)
	);

	tovl_fetch u_fetch (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (loc_valid),
		.in_ready   (loc_ready),
		.in_loc     (loc),
		.out_valid  (fetch_valid),
		.out_ready  (fetch_ready),
		.out_fetch  (fetch),
		.stamp_bits (stamp_bits),
		.label_bits (label_bits)
	);

	tovl_blend u_blend (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (fetch_valid),
		.in_ready   (fetch_ready),
		.in_fetch   (fetch),
		.stamp_bits (stamp_bits),
		.label_bits (label_bits),
		.out_valid  (overlay.valid),
		.out_ready  (overlay.ready),
		.out_rgb    (out_rgb)
	);

	assign overlay.out_red   = out_rgb.red;
	assign overlay.out_green = out_rgb.green;
	assign overlay.out_blue  = out_rgb.blue;
endmodule

// ===== hw/rtl/tovl_ram.sv =====
module tovl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ===== hw/rtl/tovl_locate.sv =====
module tovl_locate (
	input  logic            clk,
	input  logic            arst_n,
	input  tovl_pkg::cfg_t  cfg,
	input  logic            in_valid,
	output logic            in_ready,
	input  tovl_pkg::item_t in_item,
	output logic            out_valid,
	input  logic            out_ready,
	output tovl_pkg::loc_t  out_loc
);
	import tovl_pkg::*;

	logic   v_s1, v_s2;
	item_t  item_s1;
	loc_t   loc_s2;
	loc_t   loc_nxt;
	logic   rdy_s1, rdy_s2;

	logic              in_frame, label_on;
	logic [12:0]       xe, ye;
	len_t              s_len, l_len;
	logic [TW_W-1:0]   s_tw, l_tw;
	logic [13:0]       s_x0_raw;
	logic [12:0]       s_x0, s_tx0, s_dx, s_dy;
	logic [12:0]       l_y0, l_ty0, l_dx, l_dy;

	assign rdy_s2   = !v_s2 || out_ready;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	assign out_valid = v_s2;
	assign out_loc   = loc_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				v_s1 <= in_valid;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			item_s1 <= in_item;
		end
		if (rdy_s2 && v_s1) begin
			loc_s2 <= loc_nxt;
		end
	end

	// strip geometry
	assign xe = {1'b0, item_s1.x};
	assign ye = {1'b0, item_s1.y};
	assign in_frame = (item_s1.mode == MODE_PIXEL) &&
	                  (item_s1.x < cfg.width) && (item_s1.y < cfg.height);
	assign label_on = cfg.label_en && (cfg.label_len != '0);

	assign s_len = (cfg.stamp_len > len_t'(TEXT_SLOTS)) ? len_t'(TEXT_SLOTS) : cfg.stamp_len;
	assign l_len = (cfg.label_len > len_t'(TEXT_SLOTS)) ? len_t'(TEXT_SLOTS) : cfg.label_len;
	assign s_tw  = TW_W'(s_len) << COL_W;
	assign l_tw  = TW_W'(l_len) << COL_W;

	// stamp: right-aligned, clamped at column 0
	assign s_x0_raw = 14'(cfg.width) - 14'(s_tw) - 14'(2 * PAD_H + EDGE_GAP_X);
	assign s_x0     = s_x0_raw[13] ? '0 : s_x0_raw[12:0];
	assign s_tx0    = s_x0 + 13'(PAD_H);
	assign s_dx     = xe - s_tx0;
	assign s_dy     = ye - 13'(EDGE_GAP_Y + PAD_V);

	// label: bottom-aligned, clamped at row 0
	assign l_y0  = (cfg.height >= coord_t'(STRIP_H + EDGE_GAP_Y)) ?
	               13'(cfg.height - coord_t'(STRIP_H + EDGE_GAP_Y)) : '0;
	assign l_ty0 = l_y0 + 13'(PAD_V);
	assign l_dx  = xe - 13'(EDGE_GAP_X + PAD_H);
	assign l_dy  = ye - l_ty0;

	always_comb begin
		loc_nxt          = '0;
		loc_nxt.pixel    = (item_s1.mode == MODE_PIXEL);
		loc_nxt.font_we  = (item_s1.mode == MODE_FONT) && (item_s1.addr < taddr_t'(FONT_DEPTH));
		loc_nxt.glyph_we = (item_s1.mode == MODE_GLYPH);
		loc_nxt.rgb      = item_s1.rgb;
		loc_nxt.addr     = item_s1.addr;
		loc_nxt.data     = item_s1.data;

		loc_nxt.stamp.rect = in_frame && cfg.stamp_en &&
		                     (xe >= s_x0) && (xe < s_x0 + 13'(2 * PAD_H) + 13'(s_tw)) &&
		                     (ye >= 13'(EDGE_GAP_Y)) && (ye < 13'(EDGE_GAP_Y + STRIP_H));
		loc_nxt.stamp.text = in_frame && cfg.stamp_en &&
		                     (xe >= s_tx0) && (xe < s_tx0 + 13'(s_tw)) &&
		                     (ye >= 13'(EDGE_GAP_Y + PAD_V)) &&
		                     (ye < 13'(EDGE_GAP_Y + PAD_V + FONT_ROWS));
		loc_nxt.stamp.slot = s_dx[COL_W +: SLOT_W];
		loc_nxt.stamp.col  = s_dx[COL_W-1:0];
		loc_nxt.stamp.row  = s_dy[ROW_W-1:0];

		loc_nxt.label.rect = in_frame && label_on &&
		                     (xe >= 13'(EDGE_GAP_X)) &&
		                     (xe < 13'(EDGE_GAP_X + 2 * PAD_H) + 13'(l_tw)) &&
		                     (ye >= l_y0) && (ye < l_y0 + 13'(STRIP_H));
		loc_nxt.label.text = in_frame && label_on &&
		                     (xe >= 13'(EDGE_GAP_X + PAD_H)) &&
		                     (xe < 13'(EDGE_GAP_X + PAD_H) + 13'(l_tw)) &&
		                     (ye >= l_ty0) && (ye < l_ty0 + 13'(FONT_ROWS));
		loc_nxt.label.slot = l_dx[COL_W +: SLOT_W];
		loc_nxt.label.col  = l_dx[COL_W-1:0];
		loc_nxt.label.row  = l_dy[ROW_W-1:0];
	end
endmodule

// ===== hw/rtl/tovl_fetch.sv =====
module tovl_fetch (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  tovl_pkg::loc_t   in_loc,
	output logic             out_valid,
	input  logic             out_ready,
	output tovl_pkg::fetch_t out_fetch,
	output tovl_pkg::tdata_t stamp_bits,
	output tovl_pkg::tdata_t label_bits
);
	import tovl_pkg::*;

	logic [GLYPH_W-1:0] stamp_glyph_q [TEXT_SLOTS];
	logic [GLYPH_W-1:0] label_glyph_q [TEXT_SLOTS];

	logic               v_s3;
	fetch_t             fetch_s3;
	logic               rdy_s3, adv;
	taddr_t             label_slot_addr;
	logic [GLYPH_W-1:0] s_glyph, l_glyph;
	logic [FADDR_W-1:0] s_faddr, l_faddr;

	assign rdy_s3   = !v_s3 || out_ready;
	assign in_ready = rdy_s3;
	assign adv      = in_valid && rdy_s3;

	assign out_valid = v_s3;
	assign out_fetch = fetch_s3;

	// glyph strings: write and read in the same stage keeps item order
	assign label_slot_addr = in_loc.addr - taddr_t'(TEXT_SLOTS);

	always_ff @(posedge clk) begin
		if (adv && in_loc.glyph_we) begin
			if (in_loc.addr < taddr_t'(TEXT_SLOTS)) begin
				stamp_glyph_q[in_loc.addr[SLOT_W-1:0]] <= in_loc.data[GLYPH_W-1:0];
			end else if (in_loc.addr < taddr_t'(2 * TEXT_SLOTS)) begin
				label_glyph_q[label_slot_addr[SLOT_W-1:0]] <= in_loc.data[GLYPH_W-1:0];
			end
		end
	end

	assign s_glyph = stamp_glyph_q[in_loc.stamp.slot];
	assign l_glyph = label_glyph_q[in_loc.label.slot];
	assign s_faddr = FADDR_W'(s_glyph) * FADDR_W'(FONT_ROWS) + FADDR_W'(in_loc.stamp.row);
	assign l_faddr = FADDR_W'(l_glyph) * FADDR_W'(FONT_ROWS) + FADDR_W'(in_loc.label.row);

	// one font copy per strip so both can be read for the same pixel
	tovl_ram #(.WIDTH(8), .DEPTH(FONT_DEPTH)) u_stamp_font (
		.clk   (clk),
		.we    (adv && in_loc.font_we),
		.waddr (in_loc.addr[FADDR_W-1:0]),
		.wdata (in_loc.data),
		.re    (adv && in_loc.pixel),
		.raddr (s_faddr),
		.rdata (stamp_bits)
	);

	tovl_ram #(.WIDTH(8), .DEPTH(FONT_DEPTH)) u_label_font (
		.clk   (clk),
		.we    (adv && in_loc.font_we),
		.waddr (in_loc.addr[FADDR_W-1:0]),
		.wdata (in_loc.data),
		.re    (adv && in_loc.pixel),
		.raddr (l_faddr),
		.rdata (label_bits)
	);

	// load items end here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (rdy_s3) begin
			v_s3 <= in_valid && in_loc.pixel;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fetch_s3.rgb        <= in_loc.rgb;
			fetch_s3.stamp_rect <= in_loc.stamp.rect;
			fetch_s3.stamp_text <= in_loc.stamp.text;
			fetch_s3.stamp_col  <= in_loc.stamp.col;
			fetch_s3.label_rect <= in_loc.label.rect;
			fetch_s3.label_text <= in_loc.label.text;
			fetch_s3.label_col  <= in_loc.label.col;
		end
	end
endmodule

// ===== hw/rtl/tovl_blend.sv =====
module tovl_blend (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  tovl_pkg::fetch_t in_fetch,
	input  tovl_pkg::tdata_t stamp_bits,
	input  tovl_pkg::tdata_t label_bits,
	output logic             out_valid,
	input  logic             out_ready,
	output tovl_pkg::rgb_t   out_rgb
);
	import tovl_pkg::*;

	logic v_s4, v_s5;
	rgb_t rgb_s4, rgb_s5;
	logic label_rect_s4, label_hit_s4;
	logic rdy_s4, rdy_s5;
	rgb_t stamp_rgb, label_rgb;

	assign rdy_s5   = !v_s5 || out_ready;
	assign rdy_s4   = !v_s4 || rdy_s5;
	assign in_ready = rdy_s4;

	assign out_valid = v_s5;
	assign out_rgb   = rgb_s5;

	// stamp strip first
	always_comb begin
		stamp_rgb = in_fetch.rgb;
		if (in_fetch.stamp_rect) begin
			stamp_rgb = div3_rgb(stamp_rgb);
		end
		if (in_fetch.stamp_text &&
		    stamp_bits[COL_W'(FONT_COLS - 1) - in_fetch.stamp_col]) begin
			stamp_rgb = RGB_WHITE;
		end
	end

	// then label strip
	always_comb begin
		label_rgb = rgb_s4;
		if (label_rect_s4) begin
			label_rgb = div3_rgb(label_rgb);
		end
		if (label_hit_s4) begin
			label_rgb = RGB_WHITE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy_s4) begin
				v_s4 <= in_valid;
			end
			if (rdy_s5) begin
				v_s5 <= v_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s4 && in_valid) begin
			rgb_s4        <= stamp_rgb;
			label_rect_s4 <= in_fetch.label_rect;
			label_hit_s4  <= in_fetch.label_text &&
			                 label_bits[COL_W'(FONT_COLS - 1) - in_fetch.label_col];
		end
		if (rdy_s5 && v_s4) begin
			rgb_s5 <= label_rgb;
		end
	end
endmodule

// ===== hw/rtl/tovl_checker.sv =====
module tovl_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            in_valid,
	input logic            in_ready,
	input tovl_pkg::mode_t in_mode,
	input logic            out_valid,
	input logic            out_ready,
	input tovl_pkg::chan_t out_red,
	input tovl_pkg::chan_t out_green,
	input tovl_pkg::chan_t out_blue
);
	import tovl_pkg::*;

	logic acc_pixel;

	assign acc_pixel = in_valid && in_ready && (in_mode == MODE_PIXEL);

	// a waiting result stays
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// a waiting result keeps its value
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_red) && $stable(out_green) && $stable(out_blue))
		else $error("result changed while stalled");

	// nothing comes out right after reset
	a_reset_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !out_valid)
		else $error("result right after reset");

	// only a stalled full output can push back on the feed
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("feed stalled without output stall");

	// with the output always taken, an accepted pixel shows up on the output
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		acc_pixel ##1 out_ready ##1 out_ready ##1 out_ready ##1 out_ready |=> out_valid)
		else $error("pixel result late");
endmodule

bind text_overlay_pixel_compositor tovl_checker u_tovl_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (feed.valid),
	.in_ready  (feed.ready),
	.in_mode   (feed.mode),
	.out_valid (overlay.valid),
	.out_ready (overlay.ready),
	.out_red   (overlay.out_red),
	.out_green (overlay.out_green),
	.out_blue  (overlay.out_blue)
);

// ===== dv/tb_top.sv =====
module tb_top;
	import tovl_pkg::*;

	// mode 3 has no name in the package; the block drops it without a result
	localparam mode_t MODE_UNUSED = 2'd3;

	// after the last result comes back, idle for SETTLE_CYCLES before touching
	// registers so trailing load items are surely done
	localparam int SETTLE_CYCLES = 8;
	// long receiver hold-off, well beyond the pipeline depth, so the input backs up
	localparam int HOLD_CYCLES = 40;
	localparam int PHASES = 12;
	localparam int ITEMS_PER_PHASE = 64;
	// glyph strings only ever point at glyphs 0..LOADED_GLYPHS-1 (plus the last
	// glyph from the directed rows); only those font rows are preloaded
	localparam int LOADED_GLYPHS = 16;

	typedef struct {
		cfg_t  cfg;
		item_t it;
		bit    typed;
		rgb_t  want;
	} overlay_case_t;

	logic      clk;
	logic      arst_n;
	logic      cfg_we;
	cfg_idx_t  cfg_index;
	cfg_word_t cfg_data;

	tovl_in_if  feed_if ();
	tovl_out_if ovl_if ();

	text_overlay_pixel_compositor u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.feed      (feed_if),
		.overlay   (ovl_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Our own copy of what the block holds: font bitmap, both glyph strings
	// and the register file as last written.
	logic [7:0]         glyph_font  [FONT_DEPTH];
	logic [GLYPH_W-1:0] stamp_chars [TEXT_SLOTS];
	logic [GLYPH_W-1:0] label_chars [TEXT_SLOTS];
	cfg_t               live_cfg;

	rgb_t          pending_rgb [$];
	overlay_case_t overlay_cases [$];

	int  mismatch_count;
	int  n_pixels, n_font, n_glyph, n_dropped, n_cfg;
	bit  no_gaps;
	bit  stall_req;

	// Darken one strip's box, then paint white where the font bit under the
	// pixel is set. Box is the text plus PAD_H/PAD_V on each side.
	function automatic rgb_t strip_paint(rgb_t c, int x, int y, int x0, int y0, int len,
			bit on_label);
		int         text_w;
		int         dx;
		int         dy;
		int         g;
		logic [7:0] bits;
		text_w = len * FONT_COLS;
		if (x >= x0 && x < x0 + text_w + 2 * PAD_H && y >= y0 && y < y0 + STRIP_H) begin
			c.red   = c.red / 3;
			c.green = c.green / 3;
			c.blue  = c.blue / 3;
		end
		dx = x - x0 - PAD_H;
		dy = y - y0 - PAD_V;
		if (dx >= 0 && dx < text_w && dy >= 0 && dy < FONT_ROWS) begin
			g = on_label ? label_chars[dx / FONT_COLS] : stamp_chars[dx / FONT_COLS];
			bits = glyph_font[g * FONT_ROWS + dy];
			// MSB of a font row is the leftmost column
			if (bits[FONT_COLS - 1 - dx % FONT_COLS])
				c = RGB_WHITE;
		end
		return c;
	endfunction

	// Expected output pixel for a pixel item under the current registers.
	function automatic rgb_t composite_pixel(item_t it);
		rgb_t c;
		int   x;
		int   y;
		int   w;
		int   h;
		int   len;
		int   org;
		c = it.rgb;
		x = int'(it.x);
		y = int'(it.y);
		w = int'(live_cfg.width);
		h = int'(live_cfg.height);
		// outside the frame: untouched
		if (x < w && y < h) begin
			// stamp first: top right, origin pulled left by the text width, floored at 0
			if (live_cfg.stamp_en) begin
				len = (live_cfg.stamp_len > TEXT_SLOTS) ? TEXT_SLOTS : int'(live_cfg.stamp_len);
				org = w - len * FONT_COLS - 2 * PAD_H - EDGE_GAP_X;
				if (org < 0)
					org = 0;
				c = strip_paint(c, x, y, org, EDGE_GAP_Y, len, 1'b0);
			end
			// label second, and only with a nonzero length; bottom left
			if (live_cfg.label_en && live_cfg.label_len != 0) begin
				len = (live_cfg.label_len > TEXT_SLOTS) ? TEXT_SLOTS : int'(live_cfg.label_len);
				org = h - STRIP_H - EDGE_GAP_Y;
				if (org < 0)
					org = 0;
				c = strip_paint(c, x, y, EDGE_GAP_X, org, len, 1'b1);
			end
		end
		return c;
	endfunction

	// Glyph index for a string slot: one of the preloaded glyphs, with the top
	// bit sometimes set so the modulo wrap gets exercised.
	function automatic tdata_t glyph_code();
		tdata_t d;
		d = tdata_t'($urandom_range(0, LOADED_GLYPHS - 1));
		if ($urandom_range(0, 1) == 1)
			d[7] = 1'b1;
		return d;
	endfunction

	// Offer one item after a random gap, wait for the handshake, then update
	// the local store or queue the expected pixel.
	task automatic push_item(input item_t it, input bit typed, input rgb_t want);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 17);
		if (gap != 0) begin
			feed_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		feed_if.valid         <= 1'b1;
		feed_if.mode          <= it.mode;
		feed_if.pix_x         <= it.x;
		feed_if.pix_y         <= it.y;
		feed_if.pix_red       <= it.rgb.red;
		feed_if.pix_green     <= it.rgb.green;
		feed_if.pix_blue      <= it.rgb.blue;
		feed_if.table_address <= it.addr;
		feed_if.table_data    <= it.data;
		@(posedge clk);
		while (!feed_if.ready)
			@(posedge clk);
		// accepted at this edge
		case (it.mode)
			MODE_PIXEL: begin
				pending_rgb.push_back(typed ? want : composite_pixel(it));
				n_pixels++;
			end
			MODE_FONT: begin
				// writes past the font store are dropped
				if (it.addr < FONT_DEPTH) begin
					glyph_font[it.addr] = it.data;
					n_font++;
				end else begin
					n_dropped++;
				end
			end
			MODE_GLYPH: begin
				// glyph index kept modulo the glyph count; slots past both strings dropped
				if (it.addr < TEXT_SLOTS) begin
					stamp_chars[it.addr] = it.data[GLYPH_W-1:0];
					n_glyph++;
				end else if (it.addr < 2 * TEXT_SLOTS) begin
					label_chars[it.addr - TEXT_SLOTS] = it.data[GLYPH_W-1:0];
					n_glyph++;
				end else begin
					n_dropped++;
				end
			end
			default: n_dropped++;
		endcase
	endtask

	// Stop offering, wait until every queued pixel came back, then let the
	// pipeline run dry for as many more edges as extra asks for.
	task automatic settle(input int extra);
		feed_if.valid <= 1'b0;
		while (pending_rgb.size() != 0)
			@(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	// Registers only change with the pipeline empty.
	task automatic write_regs(input cfg_t nc);
		cfg_idx_t  idx  [6];
		cfg_word_t word [6];
		settle(SETTLE_CYCLES);
		idx  = '{REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT, REG_STAMP_ENABLE,
			REG_LABEL_ENABLE, REG_STAMP_LENGTH, REG_LABEL_LENGTH};
		word = '{nc.width, nc.height, cfg_word_t'(nc.stamp_en), cfg_word_t'(nc.label_en),
			cfg_word_t'(nc.stamp_len), cfg_word_t'(nc.label_len)};
		for (int i = 0; i < 6; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= word[i];
			@(posedge clk);
		end
		cfg_we   <= 1'b0;
		live_cfg = nc;
		n_cfg++;
	endtask

	function automatic void add_case(cfg_t c, mode_t m, coord_t x, coord_t y, rgb_t px,
			taddr_t a, tdata_t d, bit typed, rgb_t want);
		overlay_case_t oc;
		oc.cfg   = c;
		oc.it    = '{mode: m, x: x, y: y, rgb: px, addr: a, data: d};
		oc.typed = typed;
		oc.want  = want;
		overlay_cases.push_back(oc);
	endfunction

	// Register setting for each random phase: the first few pin the extremes,
	// the rest are drawn, mostly frames a strip can fit in.
	function automatic cfg_t phase_cfg(int p);
		cfg_t c;
		case (p)
			0: c = '{width: 12'd4095, height: 12'd4095, stamp_en: 1'b1, label_en: 1'b1,
				stamp_len: 5'd24, label_len: 5'd24};
			1: c = '{width: 12'd1, height: 12'd1, stamp_en: 1'b1, label_en: 1'b1,
				stamp_len: 5'd0, label_len: 5'd31};
			2: c = '{width: coord_t'($urandom_range(20, 60)), height: coord_t'($urandom_range(16, 40)),
				stamp_en: 1'b1, label_en: 1'b1,
				stamp_len: len_t'($urandom_range(1, 4)), label_len: len_t'($urandom_range(1, 4))};
			3: c = '{width: WIDTH_RESET, height: HEIGHT_RESET, stamp_en: 1'b1, label_en: 1'b1,
				stamp_len: 5'd31, label_len: 5'd0};
			default: begin
				c.width  = ($urandom_range(0, 4) == 0) ? coord_t'($urandom_range(1, 4095))
					: coord_t'($urandom_range(24, 900));
				c.height = ($urandom_range(0, 4) == 0) ? coord_t'($urandom_range(1, 4095))
					: coord_t'($urandom_range(24, 900));
				c.stamp_en  = ($urandom_range(0, 3) != 0);
				c.label_en  = ($urandom_range(0, 3) != 0);
				c.stamp_len = ($urandom_range(0, 4) == 0) ? len_t'($urandom_range(25, 31))
					: len_t'($urandom_range(0, 24));
				c.label_len = ($urandom_range(0, 4) == 0) ? len_t'($urandom_range(25, 31))
					: len_t'($urandom_range(0, 24));
			end
		endcase
		return c;
	endfunction

	// Mostly pixels, aimed at the strip corners where the interesting math is;
	// the rest are table loads (some past the end) and the odd unused mode.
	function automatic item_t random_item();
		item_t it;
		int    roll;
		int    sub;
		int    w;
		int    h;
		w = int'(live_cfg.width);
		h = int'(live_cfg.height);
		it.mode      = MODE_PIXEL;
		it.x         = coord_t'($urandom_range(0, 4095));
		it.y         = coord_t'($urandom_range(0, 4095));
		it.rgb.red   = chan_t'($urandom_range(0, 255));
		it.rgb.green = chan_t'($urandom_range(0, 255));
		it.rgb.blue  = chan_t'($urandom_range(0, 255));
		it.addr      = taddr_t'($urandom_range(0, 2047));
		it.data      = tdata_t'($urandom_range(0, 255));
		roll = $urandom_range(0, 99);
		if (roll < 10) begin
			it.mode = MODE_FONT;
			if (roll < 8)
				it.addr = taddr_t'($urandom_range(0, FONT_DEPTH - 1));
		end else if (roll < 19) begin
			it.mode = MODE_GLYPH;
			it.data = glyph_code();
			if (roll < 17)
				it.addr = taddr_t'($urandom_range(0, 2 * TEXT_SLOTS - 1));
		end else if (roll < 21) begin
			it.mode = MODE_UNUSED;
		end else begin
			sub = $urandom_range(0, 99);
			if (sub < 35) begin
				// top-right corner
				it.x = coord_t'($urandom_range(w > 220 ? w - 220 : 0, w - 1));
				it.y = coord_t'($urandom_range(0, h - 1 < 24 ? h - 1 : 24));
			end else if (sub < 70) begin
				// bottom-left corner
				it.x = coord_t'($urandom_range(0, w - 1 < 210 ? w - 1 : 210));
				it.y = coord_t'($urandom_range(h > 24 ? h - 24 : 0, h - 1));
			end else if (sub < 88) begin
				it.x = coord_t'($urandom_range(0, w - 1));
				it.y = coord_t'($urandom_range(0, h - 1));
			end
			// else keep the full-range coordinates, mostly off-frame
		end
		return it;
	endfunction

	// Result side: random ready gaps, one long hold-off on request, and the
	// field-by-field compare against the oldest queued pixel.
	initial begin
		int   gap;
		rgb_t want;
		ovl_if.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (stall_req) begin
				ovl_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				stall_req = 1'b0;
			end else begin
				gap = no_gaps ? 0 : $urandom_range(0, 17);
				if (gap != 0) begin
					ovl_if.ready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			ovl_if.ready <= 1'b1;
			@(posedge clk);
			while (!ovl_if.valid)
				@(posedge clk);
			if (pending_rgb.size() == 0) begin
				$error("overlay item with nothing pending: %0h %0h %0h",
					ovl_if.out_red, ovl_if.out_green, ovl_if.out_blue);
				mismatch_count++;
			end else begin
				want = pending_rgb.pop_front();
				if (ovl_if.out_red !== want.red) begin
					$error("out_red: expected %0h, got %0h", want.red, ovl_if.out_red);
					mismatch_count++;
				end
				if (ovl_if.out_green !== want.green) begin
					$error("out_green: expected %0h, got %0h", want.green, ovl_if.out_green);
					mismatch_count++;
				end
				if (ovl_if.out_blue !== want.blue) begin
					$error("out_blue: expected %0h, got %0h", want.blue, ovl_if.out_blue);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		#(8 * 600000);
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		cfg_t  c_rst;
		cfg_t  c_empty;
		cfg_t  c_glyph;
		cfg_t  c_both;
		cfg_t  c_max;
		cfg_t  c_tiny;
		item_t it;
		int    n;
		int    k;
		int    g;

		mismatch_count = 0;
		n_pixels  = 0;
		n_font    = 0;
		n_glyph   = 0;
		n_dropped = 0;
		n_cfg     = 0;
		no_gaps   = 1'b0;
		stall_req = 1'b0;

		arst_n                <= 1'b0;
		cfg_we                <= 1'b0;
		cfg_index             <= REG_IMAGE_WIDTH;
		cfg_data              <= '0;
		feed_if.valid         <= 1'b0;
		feed_if.mode          <= MODE_PIXEL;
		feed_if.pix_x         <= '0;
		feed_if.pix_y         <= '0;
		feed_if.pix_red       <= '0;
		feed_if.pix_green     <= '0;
		feed_if.pix_blue      <= '0;
		feed_if.table_address <= '0;
		feed_if.table_data    <= '0;

		c_rst   = '{width: WIDTH_RESET, height: HEIGHT_RESET, stamp_en: 1'b0, label_en: 1'b0,
			stamp_len: 5'd0, label_len: 5'd0};
		live_cfg = c_rst;
		// stamp enabled with no glyphs: a 6-wide dark box, label hidden by length 0
		c_empty = '{width: WIDTH_RESET, height: HEIGHT_RESET, stamp_en: 1'b1, label_en: 1'b1,
			stamp_len: 5'd0, label_len: 5'd0};
		// one stamp glyph: box at x 620..633, text from (623,6)
		c_glyph = '{width: WIDTH_RESET, height: HEIGHT_RESET, stamp_en: 1'b1, label_en: 1'b0,
			stamp_len: 5'd1, label_len: 5'd0};
		// tiny frame where the two strips overlap
		c_both  = '{width: 12'd30, height: 12'd20, stamp_en: 1'b1, label_en: 1'b1,
			stamp_len: 5'd1, label_len: 5'd1};
		// largest frame, lengths past the slot count
		c_max   = '{width: 12'd4095, height: 12'd4095, stamp_en: 1'b1, label_en: 1'b1,
			stamp_len: 5'd31, label_len: 5'd31};
		// 1x1 frame, both origins clamp to 0
		c_tiny  = '{width: 12'd1, height: 12'd1, stamp_en: 1'b1, label_en: 1'b1,
			stamp_len: 5'd23, label_len: 5'd24};

		// reset values: strips off, so every in-frame pixel passes through
		add_case(c_rst, MODE_PIXEL, 12'd0, 12'd0, 24'h000000, '0, '0, 1'b1, 24'h000000);
		add_case(c_rst, MODE_PIXEL, 12'd639, 12'd479, 24'hFFFFFF, '0, '0, 1'b1, 24'hFFFFFF);
		add_case(c_rst, MODE_PIXEL, 12'd640, 12'd0, 24'h123456, '0, '0, 1'b1, 24'h123456);
		add_case(c_rst, MODE_PIXEL, 12'd4095, 12'd4095, 24'hA55AC3, 11'h7FF, 8'hFF, 1'b1,
			24'hA55AC3);
		add_case(c_rst, MODE_UNUSED, 12'd4095, 12'd4095, 24'hFFFFFF, 11'h7FF, 8'hFF, 1'b0, '0);
		// loads past the end of the font store and the string slots are dropped
		add_case(c_rst, MODE_FONT, '0, '0, '0, 11'h7FF, 8'hFF, 1'b0, '0);
		add_case(c_rst, MODE_FONT, '0, '0, '0, taddr_t'(FONT_DEPTH), 8'hFF, 1'b0, '0);
		add_case(c_rst, MODE_GLYPH, '0, '0, '0, taddr_t'(2 * TEXT_SLOTS), 8'hFF, 1'b0, '0);
		add_case(c_rst, MODE_GLYPH, '0, '0, '0, 11'h7FF, 8'h00, 1'b0, '0);
		// empty stamp: box x 628..633, y 4..19
		add_case(c_empty, MODE_PIXEL, 12'd628, 12'd4, 24'hFFFFFF, '0, '0, 1'b1, 24'h555555);
		add_case(c_empty, MODE_PIXEL, 12'd633, 12'd19, 24'h030405, '0, '0, 1'b1, 24'h010101);
		add_case(c_empty, MODE_PIXEL, 12'd634, 12'd4, 24'h909090, '0, '0, 1'b1, 24'h909090);
		add_case(c_empty, MODE_PIXEL, 12'd6, 12'd460, 24'h909090, '0, '0, 1'b1, 24'h909090);
		// glyph index 255 wraps to 127; its first row gets only the leftmost bit
		add_case(c_glyph, MODE_GLYPH, '0, '0, '0, 11'd0, 8'hFF, 1'b0, '0);
		add_case(c_glyph, MODE_FONT, '0, '0, '0, taddr_t'(127 * FONT_ROWS), 8'h80, 1'b0, '0);
		add_case(c_glyph, MODE_PIXEL, 12'd623, 12'd6, 24'h102030, '0, '0, 1'b1, 24'hFFFFFF);
		add_case(c_glyph, MODE_PIXEL, 12'd624, 12'd6, 24'h306090, '0, '0, 1'b1, 24'h102030);
		add_case(c_glyph, MODE_PIXEL, 12'd620, 12'd4, 24'hFF00FF, '0, '0, 1'b1, 24'h550055);
		// overlap: darkened twice, one point inside the label text
		add_case(c_both, MODE_PIXEL, 12'd12, 12'd10, 24'hC8F064, '0, '0, 1'b0, '0);
		add_case(c_both, MODE_PIXEL, 12'd10, 12'd14, 24'hFFFFFF, '0, '0, 1'b1, 24'h1C1C1C);
		add_case(c_max, MODE_PIXEL, 12'd4094, 12'd4094, 24'hFFFFFF, '0, '0, 1'b1, 24'hFFFFFF);
		add_case(c_max, MODE_PIXEL, 12'd3894, 12'd6, 24'h7F8081, '0, '0, 1'b0, '0);
		// last column of the last slot, last font row
		add_case(c_max, MODE_PIXEL, 12'd200, 12'd4088, 24'hFE01AA, '0, '0, 1'b0, '0);
		add_case(c_tiny, MODE_PIXEL, 12'd0, 12'd0, 24'h3C3C3C, '0, '0, 1'b1, 24'h3C3C3C);
		add_case(c_tiny, MODE_PIXEL, 12'd1, 12'd0, 24'h3C3C3C, '0, '0, 1'b1, 24'h3C3C3C);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Load every font row a string can point at (the low glyphs and the
		// last one) and both strings first, back to back, so no pixel ever
		// lands on an entry that was never loaded.
		no_gaps = 1'b1;
		for (int q = 0; q <= LOADED_GLYPHS; q++) begin
			g = (q == LOADED_GLYPHS) ? GLYPH_COUNT - 1 : q;
			for (int r = 0; r < FONT_ROWS; r++) begin
				it = '{mode: MODE_FONT, x: '0, y: '0, rgb: '0,
					addr: taddr_t'(g * FONT_ROWS + r),
					data: tdata_t'($urandom_range(0, 255))};
				push_item(it, 1'b0, '0);
			end
		end
		for (int s = 0; s < 2 * TEXT_SLOTS; s++) begin
			it = '{mode: MODE_GLYPH, x: '0, y: '0, rgb: '0, addr: taddr_t'(s),
				data: glyph_code()};
			push_item(it, 1'b0, '0);
		end
		no_gaps = 1'b0;

		foreach (overlay_cases[i]) begin
			if (overlay_cases[i].cfg != live_cfg)
				write_regs(overlay_cases[i].cfg);
			push_item(overlay_cases[i].it, overlay_cases[i].typed, overlay_cases[i].want);
		end

		// Random phases. Every fourth one runs with no idling on either side;
		// phase 5 also holds the receiver off long enough to back up the
		// input, and phase 6 stops halfway until all pixels are back.
		for (int p = 0; p < PHASES; p++) begin
			write_regs(phase_cfg(p));
			no_gaps = (p % 4 == 1);
			n = 0;
			k = 0;
			while (n < ITEMS_PER_PHASE) begin
				it = random_item();
				if (p == 5 && k == 20)
					stall_req = 1'b1;
				if (p == 6 && k == ITEMS_PER_PHASE / 2)
					settle(1);
				push_item(it, 1'b0, '0);
				k++;
				if (it.mode == MODE_PIXEL
						|| (it.mode == MODE_FONT && it.addr < FONT_DEPTH)
						|| (it.mode == MODE_GLYPH && it.addr < 2 * TEXT_SLOTS))
					n++;
			end
		end

		no_gaps = 1'b0;
		settle(2 * SETTLE_CYCLES);

		$display("Coverage: %0d pixels, %0d font rows and %0d glyph slots loaded, %0d dropped",
			n_pixels, n_font, n_glyph, n_dropped);
		$display("items, over %0d register settings; %0d field mismatches.",
			n_cfg, mismatch_count);
		if (mismatch_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
